/* rtl/core/sfrb_pkg.sv */
// ----------------------------------------------------------------------------
// sfrb_pkg
// Shared types and constants of the stereo frame ring buffer: beat layouts of
// the input and result channels and the link between control and output queue.
// ----------------------------------------------------------------------------
package sfrb_pkg;

    // fixed field widths
    localparam int SAMPLE_W = 32;
    localparam int CNT_W    = 11;
    localparam int REQ_W    = 7;

    // capacity register after reset
    localparam logic [CNT_W-1:0] CAP_RESET = 11'd1024;

    // item kinds
    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_READ  = 1'b1;

    // input beat
    typedef struct packed {
        logic                kind;
        logic [SAMPLE_W-1:0] left_sample;
        logic [SAMPLE_W-1:0] right_sample;
        logic [REQ_W-1:0]    request_frames;
    } in_beat_t;

    // result beat
    typedef struct packed {
        logic [SAMPLE_W-1:0] left_out;
        logic [SAMPLE_W-1:0] right_out;
        logic                frame_valid;
        logic                last;
        logic [CNT_W-1:0]    fill_level;
        logic [CNT_W-1:0]    free_space;
    } out_beat_t;

    // control to output queue
    typedef struct packed {
        logic      vld;
        out_beat_t beat;
    } push_t;

    // output queue status back to control
    typedef struct packed {
        logic [1:0] occ;
        logic       pop;
    } q_stat_t;

endpackage

/* rtl/core/sfrb_ram.sv */
// ----------------------------------------------------------------------------
// sfrb_ram
// Generic simple dual-port RAM: one write port, one read port with the read
// data registered.
// ----------------------------------------------------------------------------
module sfrb_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/core/sfrb_out_q.sv */
// ----------------------------------------------------------------------------
// sfrb_out_q
// Two-entry result queue. Decouples the result channel from the burst engine
// so a frame keeps flowing every cycle while the receiver takes them.
// ----------------------------------------------------------------------------
module sfrb_out_q (
    input  logic                aclk,
    input  logic                aresetn,
    input  sfrb_pkg::push_t     push,
    output sfrb_pkg::q_stat_t   stat,
    output logic                m_valid,
    input  logic                m_ready,
    output sfrb_pkg::out_beat_t m_data
);

    sfrb_pkg::out_beat_t ent_reg [2];
    logic                wr_ptr_reg;
    logic                wr_ptr_next;
    logic                rd_ptr_reg;
    logic                rd_ptr_next;
    logic [1:0]          occ_reg;
    logic [1:0]          occ_next;
    logic                pop;

    assign m_valid = (occ_reg != 2'd0);
    assign m_data  = ent_reg[rd_ptr_reg];
    assign pop     = m_valid & m_ready;

    assign stat.occ = occ_reg;
    assign stat.pop = pop;

    // pointer and occupancy update
    always_comb begin
        wr_ptr_next = push.vld ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        occ_next    = occ_reg + {1'b0, push.vld} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            occ_reg    <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            occ_reg    <= occ_next;
        end
    end

    // entry storage
    always_ff @(posedge aclk) begin
        if (push.vld) begin
            ent_reg[wr_ptr_reg] <= push.beat;
        end
    end

endmodule

/* rtl/core/sfrb_ctrl.sv */
// ----------------------------------------------------------------------------
// sfrb_ctrl
// Ring control: owns the frame memory, write/read pointers, fill count and the
// capacity register, and runs read bursts one frame per cycle into the queue while it has room.
// ----------------------------------------------------------------------------
module sfrb_ctrl #(
    parameter int DEPTH       = 1024,
    parameter int MAX_BURST   = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sfrb_pkg::in_beat_t                  s_data,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sfrb_pkg::CNT_W-1:0]          cfg_data,
    input  sfrb_pkg::q_stat_t                   stat,
    output sfrb_pkg::push_t                     push
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = sfrb_pkg::CNT_W;
    localparam int REQ_W = sfrb_pkg::REQ_W;
    localparam int SW    = sfrb_pkg::SAMPLE_W;
    localparam int MEM_W = 2 * SAMPLE_BITS;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_BURST,
        ST_EMPTY
    } state_t;

    state_t           state_reg;
    state_t           state_next;
    logic [PTR_W-1:0] wp_reg;
    logic [PTR_W-1:0] wp_next;
    logic [PTR_W-1:0] rp_reg;
    logic [PTR_W-1:0] rp_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic [CNT_W-1:0] cfg_reg;
    logic [CNT_W-1:0] cfg_next;
    logic [REQ_W-1:0] remain_reg;
    logic [REQ_W-1:0] remain_next;
    logic             iss_vld_reg;
    logic             iss_vld_next;
    logic             fv_reg;
    logic             fv_next;
    logic             last_reg;
    logic             last_next;
    logic [CNT_W-1:0] mfill_reg;
    logic [CNT_W-1:0] mfill_next;
    logic [CNT_W-1:0] mfree_reg;
    logic [CNT_W-1:0] mfree_next;

    logic [CNT_W-1:0] cap;
    logic             accept;
    logic             can_issue;
    logic [REQ_W-1:0] req_c;
    logic [CNT_W-1:0] n_frames;
    logic             ram_we;
    logic             ram_re;
    logic [MEM_W-1:0] ram_wdata;
    logic [MEM_W-1:0] ram_rdata;

    // wrap a pointer at the current capacity
    function automatic logic [PTR_W-1:0] nxt(input logic [PTR_W-1:0] p,
                                             input logic [CNT_W-1:0] c);
        logic [31:0] s;
        s = 32'(p) + 32'd1;
        return (s >= 32'(c)) ? '0 : PTR_W'(s);
    endfunction

    // effective capacity, clamped to 1..DEPTH
    always_comb begin
        if (cfg_reg == '0) begin
            cap = CNT_W'(1);
        end else if (32'(cfg_reg) > 32'(DEPTH)) begin
            cap = CNT_W'(DEPTH);
        end else begin
            cap = cfg_reg;
        end
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign accept    = s_valid & s_ready;

    // issue only when the queue will have room for the frame in flight
    assign can_issue = ({1'b0, stat.occ} + {2'b0, iss_vld_reg}) < (3'd2 + {2'b0, stat.pop});

    // burst length: request clamped to the burst limit and to the fill level
    always_comb begin
        req_c    = (s_data.request_frames > REQ_W'(MAX_BURST)) ? REQ_W'(MAX_BURST)
                                                                : s_data.request_frames;
        n_frames = ({{(CNT_W-REQ_W){1'b0}}, req_c} < fill_reg)
                   ? {{(CNT_W-REQ_W){1'b0}}, req_c} : fill_reg;
    end

    // frame memory ports
    assign ram_we    = accept && (s_data.kind == sfrb_pkg::KIND_WRITE);
    assign ram_wdata = {s_data.right_sample[SAMPLE_BITS-1:0],
                        s_data.left_sample[SAMPLE_BITS-1:0]};
    assign ram_re    = (state_reg == ST_BURST) && can_issue;

    sfrb_ram #(
        .WIDTH (MEM_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (rp_reg),
        .rdata (ram_rdata)
    );

    // next state of the ring and the burst sequencer
    always_comb begin
        state_next   = state_reg;
        wp_next      = wp_reg;
        rp_next      = rp_reg;
        fill_next    = fill_reg;
        cfg_next     = cfg_reg;
        remain_next  = remain_reg;
        iss_vld_next = 1'b0;
        fv_next      = fv_reg;
        last_next    = last_reg;
        mfill_next   = mfill_reg;
        mfree_next   = mfree_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_data.kind == sfrb_pkg::KIND_WRITE) begin
                        wp_next = nxt(wp_reg, cap);
                        if (fill_reg < cap) begin
                            fill_next = fill_reg + CNT_W'(1);
                        end else begin
                            // full: drop the oldest frame
                            rp_next = nxt(rp_reg, cap);
                        end
                    end else if (n_frames == '0) begin
                        state_next = ST_EMPTY;
                    end else begin
                        remain_next = REQ_W'(n_frames);
                        state_next  = ST_BURST;
                    end
                end
            end
            ST_EMPTY: begin
                if (can_issue) begin
                    iss_vld_next = 1'b1;
                    fv_next      = 1'b0;
                    last_next    = 1'b1;
                    mfill_next   = fill_reg;
                    mfree_next   = cap - fill_reg;
                    state_next   = ST_IDLE;
                end
            end
            ST_BURST: begin
                if (can_issue) begin
                    iss_vld_next = 1'b1;
                    fv_next      = 1'b1;
                    last_next    = (remain_reg == REQ_W'(1));
                    mfill_next   = fill_reg - CNT_W'(1);
                    mfree_next   = cap - fill_reg + CNT_W'(1);
                    rp_next      = nxt(rp_reg, cap);
                    fill_next    = fill_reg - CNT_W'(1);
                    remain_next  = remain_reg - REQ_W'(1);
                    if (remain_reg == REQ_W'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // capacity write empties the ring
        if (cfg_valid && cfg_ready) begin
            cfg_next  = cfg_data;
            wp_next   = '0;
            rp_next   = '0;
            fill_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            wp_reg      <= '0;
            rp_reg      <= '0;
            fill_reg    <= '0;
            cfg_reg     <= sfrb_pkg::CAP_RESET;
            remain_reg  <= '0;
            iss_vld_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            wp_reg      <= wp_next;
            rp_reg      <= rp_next;
            fill_reg    <= fill_next;
            cfg_reg     <= cfg_next;
            remain_reg  <= remain_next;
            iss_vld_reg <= iss_vld_next;
        end
        fv_reg    <= fv_next;
        last_reg  <= last_next;
        mfill_reg <= mfill_next;
        mfree_reg <= mfree_next;
    end

    // join memory data with the result fields registered at issue
    always_comb begin
        push.vld              = iss_vld_reg;
        push.beat.left_out    = fv_reg ? SW'(ram_rdata[SAMPLE_BITS-1:0]) : '0;
        push.beat.right_out   = fv_reg ? SW'(ram_rdata[MEM_W-1:SAMPLE_BITS]) : '0;
        push.beat.frame_valid = fv_reg;
        push.beat.last        = last_reg;
        push.beat.fill_level  = mfill_reg;
        push.beat.free_space  = mfree_reg;
    end

endmodule

/* rtl/core/stereo_frame_ring_buffer_top.sv */
// ----------------------------------------------------------------------------
// stereo_frame_ring_buffer_top
// Ring buffer of stereo frames with overwrite-oldest policy.
// ----------------------------------------------------------------------------
// Input channel s_*: a write beat stores one left/right frame; when the ring
// is full the oldest frame is dropped, so a full ring never holds writes. A read beat asks
// for up to request_frames frames (cut to MAX_BURST) and yields min(request,
// fill) result beats in order, last set on the final one; a read that finds
// nothing yields one beat with frame_valid low and last high. Every result
// carries fill level and free space after that beat.
// Config channel cfg_*: writes the capacity (0 acts as 1, above DEPTH acts as
// DEPTH) and empties the ring; write it only while the block is idle.
// Reads: a read holds the input until its burst is done, which sends one frame
// per cycle from the single memory read port while the result queue has room;
// an empty read holds it until its one result beat is issued. A result passes
// the memory read register and then the result queue before it shows on m_*.
// Reset empties the ring and sets the capacity to 1024; stored words are not
// cleared. When m_ready is low, a two-entry result queue fills and the burst
// pauses; write beats are still taken while no read is in progress.
// ----------------------------------------------------------------------------
module stereo_frame_ring_buffer_top #(
    parameter int DEPTH       = 1024,
    parameter int MAX_BURST   = 64,
    parameter int SAMPLE_BITS = 32
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  sfrb_pkg::in_beat_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output sfrb_pkg::out_beat_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [sfrb_pkg::CNT_W-1:0] cfg_data
);

    sfrb_pkg::push_t   push;
    sfrb_pkg::q_stat_t stat;

    // ring control and frame memory
    sfrb_ctrl #(
        .DEPTH       (DEPTH),
        .MAX_BURST   (MAX_BURST),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .stat      (stat),
        .push      (push)
    );

    // result queue
    sfrb_out_q u_out_q (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .stat    (stat),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // queue never overflows: a push into a full queue needs a pop
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (push.vld && stat.occ == 2'd2) |-> stat.pop)
        else $error("result queue overflow");

    // a read beat always blocks the input for the next cycle
    a_read_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready && s_data.kind == sfrb_pkg::KIND_READ) |=> !s_ready)
        else $error("input not held during read burst");

    // an empty-read beat is always the final beat of its request
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.frame_valid) |-> m_data.last)
        else $error("empty result without last");

endmodule
